### design/fpd_pkg.sv
package fpd_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned WordW          = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned EventW         = 3;
  localparam logic [WordW-1:0] CrcPoly   = 16'h1021;
  localparam logic [WordW-1:0] PingReplyBytes = 16'd8;

  // Event codes reported with each result
  typedef enum logic [EventW-1:0] {
    EV_NONE       = 3'd0,
    EV_OK         = 3'd1,
    EV_CRC_BAD    = 3'd2,
    EV_TOO_LONG   = 3'd3,
    EV_ACK        = 3'd4,
    EV_NAK        = 3'd5,
    EV_PING       = 3'd6,
    EV_PING_REPLY = 3'd7
  } event_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MARKER    = 3'd0,
    REG_COMMAND_TYPE    = 3'd1,
    REG_DATA_TYPE       = 3'd2,
    REG_PING_TYPE       = 3'd3,
    REG_PING_REPLY_TYPE = 3'd4,
    REG_ACK_TYPE        = 3'd5,
    REG_NAK_TYPE        = 3'd6,
    REG_MAX_PAYLOAD     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] command_type;
    logic [ByteW-1:0] data_type;
    logic [ByteW-1:0] ping_type;
    logic [ByteW-1:0] ping_reply_type;
    logic [ByteW-1:0] ack_type;
    logic [ByteW-1:0] nak_type;
    logic [WordW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic             byte_valid;
    logic [ByteW-1:0] byte_value;
    logic [WordW-1:0] byte_index;
    event_t           event_res;
    logic [ByteW-1:0] frame_kind;
    logic [WordW-1:0] frame_length;
  } result_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call
  function automatic logic [WordW-1:0] crc16_byte(input logic [WordW-1:0] crc_in,
                                                  input logic [ByteW-1:0] data);
    logic [WordW-1:0] crc;
    crc = crc_in ^ {data, {(WordW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      if (crc[WordW-1]) begin
        crc = {crc[WordW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[WordW-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### design/fpd_if.sv
// Received byte channel
interface fpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoder result channel
interface fpd_result_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [15:0] byte_index;
  logic [2:0]  event_res;
  logic [7:0]  frame_kind;
  logic [15:0] frame_length;

  modport source (output valid, output byte_valid, output byte_value, output byte_index,
                  output event_res, output frame_kind, output frame_length, input ready);
  modport sink (input valid, input byte_valid, input byte_value, input byte_index,
                input event_res, input frame_kind, input frame_length, output ready);
endinterface

### design/fpd_cfg_regs.sv
module fpd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [fpd_pkg::CfgIdxW-1:0] wr_index,
  input  logic [fpd_pkg::WordW-1:0]   wr_data,
  output fpd_pkg::cfg_t               cfg
);
  import fpd_pkg::*;

  // Load defaults on reset, take one register per write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= 8'h5A;
      cfg.command_type    <= 8'hA4;
      cfg.data_type       <= 8'hA5;
      cfg.ping_type       <= 8'hA6;
      cfg.ping_reply_type <= 8'hA7;
      cfg.ack_type        <= 8'hA1;
      cfg.nak_type        <= 8'hA2;
      cfg.max_payload     <= 16'd4096;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_START_MARKER:    cfg.start_marker    <= wr_data[ByteW-1:0];
        REG_COMMAND_TYPE:    cfg.command_type    <= wr_data[ByteW-1:0];
        REG_DATA_TYPE:       cfg.data_type       <= wr_data[ByteW-1:0];
        REG_PING_TYPE:       cfg.ping_type       <= wr_data[ByteW-1:0];
        REG_PING_REPLY_TYPE: cfg.ping_reply_type <= wr_data[ByteW-1:0];
        REG_ACK_TYPE:        cfg.ack_type        <= wr_data[ByteW-1:0];
        REG_NAK_TYPE:        cfg.nak_type        <= wr_data[ByteW-1:0];
        REG_MAX_PAYLOAD:     cfg.max_payload     <= wr_data;
        default:             cfg.max_payload     <= cfg.max_payload;
      endcase
    end
  end

endmodule

### design/fpd_parser.sv
module fpd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [fpd_pkg::ByteW-1:0] rx_byte,
  input  fpd_pkg::cfg_t             cfg,
  output fpd_pkg::result_t          res
);
  import fpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_CRCLO = 3'd4,
    PH_CRCHI = 3'd5,
    PH_DATA  = 3'd6
  } phase_t;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] kind_seen, kind_seen_next;
  logic [WordW-1:0] length_seen, length_seen_next;
  logic [WordW-1:0] crc_expected, crc_expected_next;
  logic [WordW-1:0] bytes_taken, bytes_taken_next;
  logic [WordW-1:0] crc_running, crc_running_next;
  logic [WordW-1:0] crc_step;
  logic [WordW:0]   count;
  logic             is_lc_kind;

  assign crc_step   = crc16_byte(crc_running, rx_byte);
  assign count      = {1'b0, bytes_taken} + {{WordW{1'b0}}, 1'b1};
  assign is_lc_kind = (kind_seen == cfg.command_type) || (kind_seen == cfg.data_type);

  // Work out the next frame state and the result for this beat
  always_comb begin
    phase_next        = phase;
    kind_seen_next    = kind_seen;
    length_seen_next  = length_seen;
    crc_expected_next = crc_expected;
    bytes_taken_next  = bytes_taken;
    crc_running_next  = crc_running;
    res.byte_valid    = 1'b0;
    res.byte_value    = '0;
    res.byte_index    = '0;
    res.event_res     = EV_NONE;

    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == cfg.start_marker) begin
          crc_running_next = crc16_byte('0, rx_byte);
          phase_next       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        kind_seen_next = rx_byte;
        priority if (rx_byte == cfg.command_type || rx_byte == cfg.data_type) begin
          crc_running_next = crc_step;
          phase_next       = PH_LENLO;
        end else if (rx_byte == cfg.ping_type) begin
          res.event_res = EV_PING;
          phase_next    = PH_IDLE;
        end else if (rx_byte == cfg.ping_reply_type) begin
          length_seen_next = '0;
          bytes_taken_next = '0;
          phase_next       = PH_DATA;
        end else if (rx_byte == cfg.ack_type) begin
          res.event_res = EV_ACK;
          phase_next    = PH_IDLE;
        end else if (rx_byte == cfg.nak_type) begin
          res.event_res = EV_NAK;
          phase_next    = PH_IDLE;
        end else begin
          // unknown type: keep waiting for a type byte
          phase_next = PH_TYPE;
        end
      end
      PH_LENLO: begin
        length_seen_next = {length_seen[WordW-1:ByteW], rx_byte};
        crc_running_next = crc_step;
        phase_next       = PH_LENHI;
      end
      PH_LENHI: begin
        length_seen_next = {rx_byte, length_seen[ByteW-1:0]};
        crc_running_next = crc_step;
        if ({rx_byte, length_seen[ByteW-1:0]} <= cfg.max_payload) begin
          phase_next = PH_CRCLO;
        end else begin
          res.event_res = EV_TOO_LONG;
          phase_next    = PH_IDLE;
        end
      end
      PH_CRCLO: begin
        crc_expected_next = {crc_expected[WordW-1:ByteW], rx_byte};
        phase_next        = PH_CRCHI;
      end
      PH_CRCHI: begin
        crc_expected_next = {rx_byte, crc_expected[ByteW-1:0]};
        bytes_taken_next  = '0;
        phase_next        = PH_DATA;
      end
      PH_DATA: begin
        res.byte_valid   = 1'b1;
        res.byte_value   = rx_byte;
        res.byte_index   = bytes_taken;
        crc_running_next = crc_step;
        bytes_taken_next = count[WordW-1:0];
        priority if (is_lc_kind && count >= {1'b0, length_seen}) begin
          res.event_res = (crc_step == crc_expected) ? EV_OK : EV_CRC_BAD;
          phase_next    = PH_IDLE;
        end else if (kind_seen == cfg.ping_reply_type
                     && count >= {1'b0, PingReplyBytes}) begin
          length_seen_next = PingReplyBytes;
          res.event_res    = EV_PING_REPLY;
          phase_next       = PH_IDLE;
        end else begin
          phase_next = PH_DATA;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.frame_kind   = kind_seen_next;
    res.frame_length = length_seen_next;
  end

  // Hold frame state, advance on each beat taken from the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      kind_seen    <= '0;
      length_seen  <= '0;
      crc_expected <= '0;
      bytes_taken  <= '0;
      crc_running  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      kind_seen    <= kind_seen_next;
      length_seen  <= length_seen_next;
      crc_expected <= crc_expected_next;
      bytes_taken  <= bytes_taken_next;
      crc_running  <= crc_running_next;
    end
  end

endmodule

### design/framed_packet_decoder_crc16_core.sv
// A byte taken into the input register has its result loaded into the result register, which
// drives the result channel. Throughput: one byte per cycle while the result channel is ready;
// the byte-wide CRC update and frame state step are combinational between the two registers.
// Reset (rst, synchronous, active high) empties both registers, returns the decoder to
// hunting for the start byte with all frame state zero, and loads the register defaults.
module framed_packet_decoder_crc16_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [fpd_pkg::CfgIdxW-1:0] wr_index,
  input  logic [fpd_pkg::WordW-1:0]   wr_data,
  fpd_rx_if.sink                      rx,
  fpd_result_if.source                result
);
  import fpd_pkg::*;

  cfg_t             cfg;
  result_t          res_next;
  result_t          res;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_valid;
  logic             advance;

  // Move the held byte on when the result register is free or being emptied
  assign advance  = s1_valid && (!out_valid || result.ready);
  assign rx.ready = !s1_valid || advance;

  fpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res_next)
  );

  // Input register: take a beat whenever there is room
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // Result register: load on advance, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.byte_valid   = res.byte_valid;
  assign result.byte_value   = res.byte_value;
  assign result.byte_index   = res.byte_index;
  assign result.event_res    = res.event_res;
  assign result.frame_kind   = res.frame_kind;
  assign result.frame_length = res.frame_length;

`ifndef SYNTHESIS
  a_reset_empties : assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_no_echo_on_short_frames : assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.event_res == EV_ACK || res.event_res == EV_NAK
                  || res.event_res == EV_PING || res.event_res == EV_TOO_LONG)
    |-> !res.byte_valid)
    else $error("byte echoed on a frame without payload");

  a_ping_reply_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && res.event_res == EV_PING_REPLY
    |-> res.byte_valid && res.frame_length == PingReplyBytes)
    else $error("ping response ended without its payload byte");

  a_idle_fields_clear : assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.byte_valid |-> res.byte_value == '0 && res.byte_index == '0)
    else $error("echo fields set without a payload byte");

  a_result_waits : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |=> s1_valid && $stable(s1_byte))
    else $error("input register lost a beat while the result stalled");
`endif

endmodule
